// File: sv/itrd_pkg.sv
// ---------------------------------------------------------------------------
// itrd_pkg: shared types and constants for the radix digit converter
// Holds the radix limits, the ASCII digit bases, the controller/datapath
// command and status bundles, and the digit-to-character function.
// ---------------------------------------------------------------------------
`default_nettype none

package itrd_pkg;

  // Width of the radix register and of one stored digit.
  localparam int DIGIT_W = 6;
  // Width of one ASCII character code.
  localparam int CHAR_W  = 7;

  // Radix limits and reset value.
  localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;

  // Character bases and the largest decimal digit.
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_NINE   = 7'd57;
  localparam logic [CHAR_W-1:0]  CHAR_A      = 7'd65;
  localparam logic [CHAR_W-1:0]  CHAR_Z      = 7'd90;
  localparam logic [DIGIT_W-1:0] DEC_MAX     = 6'd9;
  localparam logic [CHAR_W-1:0]  LETTER_OFS  = 7'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new item and clear the digit counters
    logic step;      // one restoring division step
    logic store;     // write the remainder as a digit
    logic rd;        // read the digit at the pointer
    logic load_out;  // move the read digit into the output register
    logic dec;       // move the pointer to the next lower digit
  } itrd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;  // the current step is the final one of a division
    logic q_zero;    // the quotient is zero
    logic ptr_zero;  // the pointer is at the least significant digit
  } itrd_status_t;

  // Maps a digit value to its ASCII character.
  function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d7;
    d7 = {1'b0, d};
    if (d <= DEC_MAX) begin
      return CHAR_ZERO + d7;
    end else begin
      return CHAR_A + d7 - LETTER_OFS;
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/itrd_ram.sv
// ---------------------------------------------------------------------------
// itrd_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module itrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/itrd_datapath.sv
// ---------------------------------------------------------------------------
// itrd_datapath: divider, digit store and output register
// A bit-serial restoring divider produces one digit per division; digits are
// kept in a small RAM and read back most significant first.
// ---------------------------------------------------------------------------
`default_nettype none

module itrd_datapath import itrd_pkg::*; #(
  parameter int VALUE_BITS = 63
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [DIGIT_W-1:0]    cfg_wr_data,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire itrd_cmd_t             cmd,
  output itrd_status_t               status,
  output logic      [CHAR_W-1:0]     char_code,
  output logic                       last
);

  localparam int CW = $clog2(VALUE_BITS);
  localparam logic [CW-1:0] LAST_BIT = CW'(VALUE_BITS - 1);

  logic [DIGIT_W-1:0]    radix;
  logic [DIGIT_W-1:0]    eff_radix;
  logic [VALUE_BITS-1:0] quot;
  logic [DIGIT_W-1:0]    rem;
  logic [CW-1:0]         bit_cnt;
  logic [CW-1:0]         ptr;
  logic [DIGIT_W:0]      trial;
  logic [DIGIT_W:0]      diff;
  logic                  ge;
  logic [DIGIT_W-1:0]    rd_digit;

  // Radix register, written by the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix <= cfg_wr_data;
    end
  end

  // Out-of-range radix values are clamped to the supported range.
  always_comb begin
    priority if (radix < RADIX_MIN) begin
      eff_radix = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      eff_radix = RADIX_MAX;
    end else begin
      eff_radix = radix;
    end
  end

  // One restoring division step: shift in the next dividend bit and subtract.
  assign trial = {rem, quot[VALUE_BITS-1]};
  assign ge    = trial >= {1'b0, eff_radix};
  assign diff  = trial - {1'b0, eff_radix};

  // Dividend/quotient shift register and partial remainder.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot <= value;
      rem  <= '0;
    end else if (cmd.step) begin
      quot <= {quot[VALUE_BITS-2:0], ge};
      rem  <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end else if (cmd.store) begin
      rem  <= '0;
    end
  end

  // Step counter within one division and digit pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
      ptr     <= '0;
    end else begin
      if (cmd.load || cmd.store) begin
        bit_cnt <= '0;
      end else if (cmd.step) begin
        bit_cnt <= bit_cnt + CW'(1);
      end
      if (cmd.load) begin
        ptr <= '0;
      end else if (cmd.store && !status.q_zero) begin
        ptr <= ptr + CW'(1);
      end else if (cmd.dec) begin
        ptr <= ptr - CW'(1);
      end
    end
  end

  // Digit store, least significant digit at address zero.
  itrd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_digits (
    .clk     (clk),
    .wr_en   (cmd.store),
    .wr_addr (ptr),
    .wr_data (rem),
    .rd_en   (cmd.rd),
    .rd_addr (ptr),
    .rd_data (rd_digit)
  );

  // Output register holding the character that waits for the receiver.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      char_code <= char_of(rd_digit);
      last      <= status.ptr_zero;
    end
  end

  assign status.div_last = bit_cnt == LAST_BIT;
  assign status.q_zero   = quot == '0;
  assign status.ptr_zero = ptr == '0;

endmodule

`default_nettype wire

// File: sv/itrd_ctrl.sv
// ---------------------------------------------------------------------------
// itrd_ctrl: sequencing state machine for the radix digit converter
// Runs the divisions until the quotient reaches zero, then reads the digits
// back and hands them to the output channel one at a time.
// ---------------------------------------------------------------------------
`default_nettype none

module itrd_ctrl import itrd_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire itrd_status_t status,
  output itrd_cmd_t         cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_STORE = 6'b000100,
    S_READ  = 6'b001000,
    S_LOAD  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = status.q_zero ? S_READ : S_DIV;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_out = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (status.ptr_zero) begin
            state_next = S_IDLE;
          end else begin
            cmd.dec    = 1'b1;
            state_next = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_OUT;

endmodule

`default_nettype wire

// File: sv/integer_to_radix_digits_core.sv
// ---------------------------------------------------------------------------
// integer_to_radix_digits_core: integer to radix digit string converter
// Converts an unsigned integer to ASCII digits in a radix from 2 to 36.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) takes one item: the value to
//   convert. The output channel (out_valid/out_ready) returns its digits as
//   ASCII characters, most significant first, with last set on the final one.
//   A zero input yields the single character '0'.
//   The radix is written through cfg_wr_en/cfg_wr_data while the block is
//   idle; values below 2 act as 2 and values above 36 act as 36.
// Operation:
//   One item is handled at a time; in_ready is high only when idle.
//   Each digit costs one division on the shared bit-serial divider, and
//   each character is then read from the digit RAM, loaded into the
//   output register and presented.
// Reset and stalls:
//   Reset returns the controller to idle and the radix to 10. A stalled
//   receiver holds the current character in the output register; nothing
//   is lost or repeated.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_digits_core import itrd_pkg::*; #(
  parameter int VALUE_BITS = 63
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [DIGIT_W-1:0]    cfg_wr_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [CHAR_W-1:0]     char_code,
  output logic                       last
);

  itrd_cmd_t    cmd;
  itrd_status_t status;

  // Sequencing state machine.
  itrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Divider, digit store and output register.
  itrd_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .value       (value),
    .cmd         (cmd),
    .status      (status),
    .char_code   (char_code),
    .last        (last)
  );

  // The block never takes an item while it is presenting a character.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while a character is pending");

  // An accepted item always starts a conversion.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("still ready right after accepting an item");

  // The final character returns the block to idle.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> in_ready)
    else $error("not idle after the final character");

  // Every presented character is a legal digit.
  a_legal_char: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((char_code >= CHAR_ZERO && char_code <= CHAR_NINE) ||
                   (char_code >= CHAR_A && char_code <= CHAR_Z)))
    else $error("illegal digit character");

endmodule

`default_nettype wire

// File: tb/integer_to_radix_digits_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// integer_to_radix_digits_core_test: self-checking bench for the converter
// Sends integers through the input channel and checks every character on
// the output channel against digits that the bench works out on its own.
// The radix register is changed between phases (the clamped values below
// two and above thirty-six among them). Idle and stall patterns change
// from phase to phase.
// ---------------------------------------------------------------------------
module integer_to_radix_digits_core_test;
  import itrd_pkg::*;

  localparam int          VALUE_W   = 63;
  localparam logic [63:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // One expected output character.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } digit_char_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [DIGIT_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CHAR_W-1:0]  char_code;
  logic               last;

  // Bench copy of the radix register and of the traffic in flight.
  logic [DIGIT_W-1:0] radix_setting = RADIX_RESET;
  logic [VALUE_W-1:0] values_to_send [$];
  digit_char_t        digit_chars_due [$];
  logic               in_taken = 1'b0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 mismatch_count = 0;
  int                 items_accepted = 0;
  int                 chars_checked = 0;
  int                 radix_writes = 0;

  integer_to_radix_digits_core #(
    .VALUE_BITS(VALUE_W)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_code  (char_code),
    .last       (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The register setting that the block actually divides by.
  function automatic logic [DIGIT_W-1:0] effective_radix(input logic [DIGIT_W-1:0] setting);
    if (setting < RADIX_MIN) return RADIX_MIN;
    if (setting > RADIX_MAX) return RADIX_MAX;
    return setting;
  endfunction

  // Splits one integer into digits and queues their characters, most
  // significant first, with the last flag on the final one.
  function automatic void queue_digit_chars(input logic [VALUE_W-1:0] n_in);
    logic [63:0]        n;
    logic [63:0]        r;
    logic [DIGIT_W-1:0] digit_buf [0:VALUE_W-1];
    int                 count;
    logic [CHAR_W-1:0]  d7;
    digit_char_t        c;
    n = {1'b0, n_in};
    r = {58'd0, effective_radix(radix_setting)};
    count = 0;
    while (n != 64'd0 && count < VALUE_W) begin
      digit_buf[count] = DIGIT_W'(n % r);
      n = n / r;
      count++;
    end
    // Zero still gives one digit.
    if (count == 0) begin
      digit_buf[0] = '0;
      count = 1;
    end
    for (int k = count - 1; k >= 0; k--) begin
      d7 = {1'b0, digit_buf[k]};
      c.code = (digit_buf[k] <= DEC_MAX) ? CHAR_ZERO + d7 : CHAR_A + d7 - LETTER_OFS;
      c.last = (k == 0);
      digit_chars_due.push_back(c);
    end
  endfunction

  // Random integer: full width, a power of the radix or one below it, or a
  // random bit length so that short strings are common.
  function automatic logic [VALUE_W-1:0] random_value();
    logic [63:0] raw;
    logic [63:0] p;
    logic [63:0] r;
    int          k;
    int          len;
    raw = {$urandom, $urandom};
    r = {58'd0, effective_radix(radix_setting)};
    case ($urandom_range(0, 7))
      0, 1: begin
        return raw[VALUE_W-1:0];
      end
      2: begin
        p = 64'd1;
        k = $urandom_range(1, 62);
        while (k > 0 && p <= VALUE_MAX / r) begin
          p = p * r;
          k--;
        end
        return VALUE_W'(p - 64'($urandom_range(0, 1)));
      end
      default: begin
        len = $urandom_range(0, VALUE_W);
        return VALUE_W'(raw & ((64'd1 << len) - 64'd1));
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Writes the radix register; only called while the block is idle.
  task automatic write_radix(input logic [DIGIT_W-1:0] setting);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= setting;
    radix_setting = setting;
    radix_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Waits until every queued item has gone in and all its characters are out.
  // The queues and in_valid are looked at on the rising edge, where the
  // driver's falling-edge updates have all settled.
  task automatic drain_items();
    while (values_to_send.size() > 0 || in_valid || digit_chars_due.size() > 0) begin
      @(posedge clk);
    end
    while (!in_ready) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  // Input driver: presents the next item once the previous one is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (values_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        value <= values_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: predicts on accepted items and checks each accepted character.
  always @(posedge clk) begin
    digit_char_t want;
    in_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (digit_chars_due.size() == 0) begin
          report_mismatch($sformatf("character 0x%0h (last %0b) with none expected",
                                    char_code, last));
        end else begin
          want = digit_chars_due.pop_front();
          if (char_code !== want.code) begin
            report_mismatch($sformatf("char_code 0x%0h, expected 0x%0h",
                                      char_code, want.code));
          end
          if (last !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
          end
          chars_checked++;
        end
      end
      if (in_valid && in_ready) begin
        queue_digit_chars(value);
        items_accepted++;
      end
    end
  end

  // Stimulus: directed cases first, then random phases.
  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Reset radix of ten: zero, one, the edges of one decimal digit, the top.
    set_idling(0, 0);
    values_to_send.push_back(VALUE_W'(0));
    values_to_send.push_back(VALUE_W'(1));
    values_to_send.push_back(VALUE_W'(9));
    values_to_send.push_back(VALUE_W'(10));
    values_to_send.push_back(VALUE_MAX[VALUE_W-1:0]);
    drain_items();

    // Radix thirty-six reaches the letter Z.
    write_radix(6'd36);
    values_to_send.push_back(VALUE_W'(35));
    values_to_send.push_back(VALUE_W'(36));
    values_to_send.push_back(VALUE_MAX[VALUE_W-1:0]);
    values_to_send.push_back(VALUE_W'(0));
    drain_items();

    // A radix of zero acts as two; the top value gives the longest string.
    write_radix(6'd0);
    values_to_send.push_back(VALUE_W'(0));
    values_to_send.push_back(VALUE_W'(1));
    values_to_send.push_back(VALUE_MAX[VALUE_W-1:0]);
    values_to_send.push_back(VALUE_W'(64'd1 << 62));
    drain_items();

    // The largest register value acts as thirty-six.
    write_radix(6'd63);
    values_to_send.push_back(VALUE_W'(35));
    values_to_send.push_back(VALUE_W'(1295));
    values_to_send.push_back(VALUE_W'(46655));
    drain_items();

    write_radix(6'd2);
    values_to_send.push_back(VALUE_W'(5));
    drain_items();

    write_radix(6'd1);
    values_to_send.push_back(VALUE_W'(6));
    drain_items();

    write_radix(6'd37);
    values_to_send.push_back(VALUE_W'(1296));
    drain_items();

    write_radix(6'd16);
    values_to_send.push_back(VALUE_W'(255));
    values_to_send.push_back(VALUE_W'(64'hABCDEF));
    values_to_send.push_back(VALUE_MAX[VALUE_W-1:0]);
    drain_items();

    // Random phases, each with its own radix and idling pattern.
    for (int ph = 0; ph < 8; ph++) begin
      write_radix((ph % 4 == 3) ? DIGIT_W'($urandom_range(0, 63))
                                : DIGIT_W'($urandom_range(2, 36)));
      case (ph % 4)
        0: set_idling(0, 0);
        1: set_idling(60, 0);
        2: set_idling(0, 60);
        default: set_idling(16, 16);
      endcase
      repeat (15) values_to_send.push_back(random_value());
      drain_items();
    end

    // Let any stray character show up before the verdict.
    repeat (300) @(negedge clk);
    $display("Converted %0d integers under %0d radix settings, %0d characters checked.",
             items_accepted, radix_writes + 1, chars_checked);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches found.", mismatch_count);
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #50_000_000;
    $display("Timeout with %0d characters still expected.", digit_chars_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
